// File: rtl/core/round_robin_disk_allocator_macros.svh
// ----------------------------------------------------------------------------
// round robin disk allocator assertion macros
// shared concurrent assertion forms, clocked on clk and held off during rst
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_DISK_ALLOCATOR_MACROS_SVH
`define ROUND_ROBIN_DISK_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define RRDA_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rrda assertion failed");

// next-cycle implication
`define RRDA_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rrda assertion failed");

`endif

// File: rtl/core/rrda_pkg.sv
// ----------------------------------------------------------------------------
// rrda_pkg
// shared constants, types and helper functions of the disk allocator
// ----------------------------------------------------------------------------
package rrda_pkg;

  localparam int MAX_SERVERS = 8;
  localparam int MAX_DISKS   = 8;
  localparam int SPACE_BITS  = 48;

  localparam int IDX_BITS     = 3;
  localparam int CNT_BITS     = 4;
  localparam int SIZE_BITS    = 48;
  localparam int OFF_BITS     = CNT_BITS + 1;
  localparam int CFG_IDX_BITS = 2;
  localparam int DEPTH        = MAX_SERVERS * MAX_DISKS;
  localparam int ADDR_BITS    = $clog2(DEPTH);

  localparam logic [CFG_IDX_BITS-1:0] CFG_SERVER_COUNT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DISK_COUNT   = 2'd1;

  localparam logic CMD_ALLOCATE = 1'b0;
  localparam logic CMD_WRITE    = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_PROBE
  } state_t;

  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [SPACE_BITS-1:0] space_t;

  typedef struct packed {
    logic   we;
    addr_t  waddr;
    space_t wdata;
    addr_t  raddr;
  } tbl_req_t;

  // zero acts as one, too large clamps to the maximum
  function automatic logic [CNT_BITS-1:0] eff_count(input logic [CNT_BITS-1:0] c,
                                                    input int maxv);
    logic [CNT_BITS-1:0] r;
    r = c;
    if (c == '0) begin
      r = CNT_BITS'(1);
    end else if (int'(c) > maxv) begin
      r = CNT_BITS'(maxv);
    end
    return r;
  endfunction

  // small value reduced modulo a count of at least one
  function automatic logic [IDX_BITS-1:0] mod_count(input logic [IDX_BITS-1:0] v,
                                                    input logic [CNT_BITS-1:0] n);
    logic [CNT_BITS-1:0] r;
    r = CNT_BITS'(v);
    for (int i = 0; i < (1 << IDX_BITS); i++) begin
      if (r >= n) begin
        r = r - n;
      end
    end
    return IDX_BITS'(r);
  endfunction

  function automatic addr_t table_addr(input logic [IDX_BITS-1:0] srv,
                                       input logic [IDX_BITS-1:0] dsk);
    return ADDR_BITS'(int'(srv) * MAX_DISKS + int'(dsk));
  endfunction

endpackage

// File: rtl/core/round_robin_disk_allocator.sv
// write item: result in the cycle after the item is taken
// allocate item: result once the probe search hits or gives up, 80 probes at most
// probes up to servers * (disks + 2), one at a time through the single read port of the free space table
// next item is taken once no search runs and the result register is free or being drained
// rst clears the table at once through per-entry valid bits, no clearing pass
// ----------------------------------------------------------------------------
// round_robin_disk_allocator
// round robin first fit allocator over a server by disk free space table
// ----------------------------------------------------------------------------
module round_robin_disk_allocator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                command,
  input  logic [rrda_pkg::SIZE_BITS-1:0]      request_size,
  input  logic [rrda_pkg::IDX_BITS-1:0]       target_server,
  input  logic [rrda_pkg::IDX_BITS-1:0]       target_disk,
  input  logic [rrda_pkg::SIZE_BITS-1:0]      space_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                found,
  output logic [rrda_pkg::IDX_BITS-1:0]       chosen_server,
  output logic [rrda_pkg::IDX_BITS-1:0]       chosen_disk,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rrda_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [rrda_pkg::CNT_BITS-1:0]       cfg_data
);

  rrda_pkg::tbl_req_t tbl_req;
  rrda_pkg::space_t   rd_space;

  rrda_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .request_size  (request_size),
    .target_server (target_server),
    .target_disk   (target_disk),
    .space_value   (space_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .found         (found),
    .chosen_server (chosen_server),
    .chosen_disk   (chosen_disk),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .tbl_req       (tbl_req),
    .rd_space      (rd_space)
  );

  rrda_table u_table (
    .clk      (clk),
    .rst      (rst),
    .req      (tbl_req),
    .rd_space (rd_space)
  );

endmodule

// File: rtl/core/rrda_table.sv
// ----------------------------------------------------------------------------
// rrda_table
// free space table: one write port, one registered read port, per-entry
// valid bits so that entries never written read as zero after reset
// ----------------------------------------------------------------------------
module rrda_table (
  input  logic              clk,
  input  logic              rst,
  input  rrda_pkg::tbl_req_t req,
  output rrda_pkg::space_t  rd_space
);

  rrda_pkg::space_t          mem [rrda_pkg::DEPTH];
  logic [rrda_pkg::DEPTH-1:0] valid;
  rrda_pkg::space_t          rdata;
  logic                      rvalid;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rvalid <= 1'b0;
    end else begin
      if (req.we) begin
        valid[req.waddr] <= 1'b1;
      end
      rvalid <= valid[req.raddr];
    end
  end

  assign rd_space = rvalid ? rdata : '0;

endmodule

// File: rtl/core/rrda_ctrl.sv
// ----------------------------------------------------------------------------
// rrda_ctrl
// command handling, round robin probe sequencer, config registers and
// result register
// ----------------------------------------------------------------------------
module rrda_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                command,
  input  logic [rrda_pkg::SIZE_BITS-1:0]      request_size,
  input  logic [rrda_pkg::IDX_BITS-1:0]       target_server,
  input  logic [rrda_pkg::IDX_BITS-1:0]       target_disk,
  input  logic [rrda_pkg::SIZE_BITS-1:0]      space_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                found,
  output logic [rrda_pkg::IDX_BITS-1:0]       chosen_server,
  output logic [rrda_pkg::IDX_BITS-1:0]       chosen_disk,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rrda_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [rrda_pkg::CNT_BITS-1:0]       cfg_data,
  output rrda_pkg::tbl_req_t                  tbl_req,
  input  rrda_pkg::space_t                    rd_space
);

  rrda_pkg::state_t                   state;
  rrda_pkg::state_t                   state_next;
  logic [rrda_pkg::CNT_BITS-1:0]      server_count;
  logic [rrda_pkg::CNT_BITS-1:0]      disk_count;
  logic [rrda_pkg::IDX_BITS-1:0]      next_server;
  logic [rrda_pkg::IDX_BITS-1:0]      disk_rotation;
  logic [rrda_pkg::IDX_BITS-1:0]      cur;
  logic [rrda_pkg::IDX_BITS-1:0]      dsk;
  logic [rrda_pkg::IDX_BITS-1:0]      start;
  logic [rrda_pkg::OFF_BITS-1:0]      off;
  logic [rrda_pkg::SIZE_BITS-1:0]     req_size;

  logic                               accept;
  logic [rrda_pkg::CNT_BITS-1:0]      sc_eff;
  logic [rrda_pkg::CNT_BITS-1:0]      nd_eff;
  logic [rrda_pkg::IDX_BITS-1:0]      start0;
  logic [rrda_pkg::IDX_BITS-1:0]      dsk0;
  logic                               wrap;
  logic [rrda_pkg::IDX_BITS-1:0]      cur_n;
  logic [rrda_pkg::IDX_BITS-1:0]      dsk_inc;
  logic [rrda_pkg::IDX_BITS-1:0]      dsk_n;
  logic [rrda_pkg::OFF_BITS-1:0]      off_n;
  logic                               hit;
  logic                               give_up;
  logic                               in_range;

  assign in_ready  = (state == rrda_pkg::ST_IDLE) && (!out_valid || out_ready);
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign sc_eff = rrda_pkg::eff_count(server_count, rrda_pkg::MAX_SERVERS);
  assign nd_eff = rrda_pkg::eff_count(disk_count, rrda_pkg::MAX_DISKS);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rrda_pkg::ST_IDLE: begin
        if (accept && command == rrda_pkg::CMD_ALLOCATE) begin
          state_next = rrda_pkg::ST_PROBE;
        end
      end
      rrda_pkg::ST_PROBE: begin
        if (hit || give_up) begin
          state_next = rrda_pkg::ST_IDLE;
        end
      end
      default: state_next = rrda_pkg::ST_IDLE;
    endcase
  end

  // probe datapath and table port
  always_comb begin
    start0 = (rrda_pkg::CNT_BITS'(next_server) < sc_eff) ? next_server : '0;
    dsk0   = rrda_pkg::mod_count(disk_rotation, nd_eff);

    // past the last server: back to server 0, one disk further
    wrap    = (rrda_pkg::CNT_BITS'(cur) + rrda_pkg::CNT_BITS'(1)) >= sc_eff;
    cur_n   = wrap ? '0 : cur + rrda_pkg::IDX_BITS'(1);
    dsk_inc = ((rrda_pkg::CNT_BITS'(dsk) + rrda_pkg::CNT_BITS'(1)) >= nd_eff) ?
              '0 : dsk + rrda_pkg::IDX_BITS'(1);
    dsk_n   = wrap ? dsk_inc : dsk;
    off_n   = off + rrda_pkg::OFF_BITS'(wrap);

    hit     = 64'(rd_space) >= 64'(req_size);
    give_up = (off_n > (rrda_pkg::OFF_BITS'(nd_eff) + rrda_pkg::OFF_BITS'(1))) &&
              (cur_n == start);

    in_range = (int'(target_server) < rrda_pkg::MAX_SERVERS) &&
               (int'(target_disk) < rrda_pkg::MAX_DISKS);

    tbl_req.we    = accept && (command == rrda_pkg::CMD_WRITE) && in_range;
    tbl_req.waddr = rrda_pkg::table_addr(target_server, target_disk);
    tbl_req.wdata = rrda_pkg::SPACE_BITS'(space_value);
    tbl_req.raddr = (state == rrda_pkg::ST_IDLE) ? rrda_pkg::table_addr(start0, dsk0) :
                                                   rrda_pkg::table_addr(cur_n, dsk_n);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= rrda_pkg::ST_IDLE;
      out_valid     <= 1'b0;
      next_server   <= '0;
      disk_rotation <= '0;
      server_count  <= rrda_pkg::CNT_BITS'(rrda_pkg::MAX_SERVERS);
      disk_count    <= rrda_pkg::CNT_BITS'(rrda_pkg::MAX_DISKS);
    end else begin
      state <= state_next;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rrda_pkg::CFG_SERVER_COUNT: server_count <= cfg_data;
          rrda_pkg::CFG_DISK_COUNT:   disk_count   <= cfg_data;
          default: ;
        endcase
      end
      if (accept && command == rrda_pkg::CMD_WRITE) begin
        out_valid <= 1'b1;
      end
      if (state == rrda_pkg::ST_PROBE && (hit || give_up)) begin
        out_valid <= 1'b1;
        if (hit) begin
          next_server   <= cur_n;
          disk_rotation <= dsk_n;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur      <= start0;
      start    <= start0;
      dsk      <= dsk0;
      off      <= '0;
      req_size <= request_size;
      if (command == rrda_pkg::CMD_WRITE) begin
        found         <= 1'b0;
        chosen_server <= '0;
        chosen_disk   <= '0;
      end
    end else if (state == rrda_pkg::ST_PROBE) begin
      cur <= cur_n;
      dsk <= dsk_n;
      off <= off_n;
      if (hit) begin
        found         <= 1'b1;
        chosen_server <= cur;
        chosen_disk   <= dsk;
      end else if (give_up) begin
        found         <= 1'b0;
        chosen_server <= '0;
        chosen_disk   <= '0;
      end
    end
  end

endmodule

// File: rtl/core/rrda_checker.sv
// ----------------------------------------------------------------------------
// rrda_checker
// port level checks of the disk allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "round_robin_disk_allocator_macros.svh"

module rrda_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                command,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic                                found,
  input logic [rrda_pkg::IDX_BITS-1:0]       chosen_server,
  input logic [rrda_pkg::IDX_BITS-1:0]       chosen_disk
);

  // a stalled result holds
  `RRDA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(found) && $stable(chosen_server) && $stable(chosen_disk))

  // a miss reports position zero
  `RRDA_ASSERT_IMP(a_miss_zero, out_valid && !found, chosen_server == '0 && chosen_disk == '0)

  // a write item answers in the next cycle with a miss
  `RRDA_ASSERT_NXT(a_write_result, in_valid && in_ready && command == rrda_pkg::CMD_WRITE, out_valid && !found)

  // no new item while a result is stuck
  `RRDA_ASSERT_IMP(a_no_take_stalled, out_valid && !out_ready, !in_ready)

endmodule

bind round_robin_disk_allocator rrda_checker u_rrda_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives write and allocate items into the disk allocator under random sender
// gaps and receiver stalls, and checks every result against a planned value or a
// local model of the free space table and the round robin search
// ----------------------------------------------------------------------------
module tb_top;
  import rrda_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 2'd3;
  localparam logic [SIZE_BITS-1:0]    SIZE_MAX     = '1;
  localparam int NUM_PHASES   = 12;
  localparam int RANDOM_ITEMS = 624;
  localparam int PLAN_ROWS    = 23;

  typedef struct packed {
    logic                found;
    logic [IDX_BITS-1:0] srv;
    logic [IDX_BITS-1:0] dsk;
  } placement_t;

  typedef struct packed {
    logic                 cmd;
    logic [SIZE_BITS-1:0] req;
    logic [IDX_BITS-1:0]  srv;
    logic [IDX_BITS-1:0]  dsk;
    logic [SIZE_BITS-1:0] space;
    logic                 given;
    logic                 want_found;
    logic [IDX_BITS-1:0]  want_srv;
    logic [IDX_BITS-1:0]  want_dsk;
  } plan_row_t;

  typedef enum int {
    RX_OPEN,
    RX_HALF,
    RX_SPOTTY,
    RX_CHOKED
  } rx_mode_t;

  logic                    clk           = 1'b0;
  logic                    rst           = 1'b1;
  logic                    in_valid      = 1'b0;
  logic                    in_ready;
  logic                    command       = CMD_ALLOCATE;
  logic [SIZE_BITS-1:0]    request_size  = '0;
  logic [IDX_BITS-1:0]     target_server = '0;
  logic [IDX_BITS-1:0]     target_disk   = '0;
  logic [SIZE_BITS-1:0]    space_value   = '0;
  logic                    out_valid;
  logic                    out_ready     = 1'b0;
  logic                    found;
  logic [IDX_BITS-1:0]     chosen_server;
  logic [IDX_BITS-1:0]     chosen_disk;
  logic                    cfg_valid     = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index     = CFG_SERVER_COUNT;
  logic [CNT_BITS-1:0]     cfg_data      = '0;

  // local copy of the allocator state
  space_t              space_copy [DEPTH] = '{default: '0};
  int                  saved_server   = 0;
  int                  saved_rotation = 0;
  logic [CNT_BITS-1:0] servers_reg    = 4'd8;
  logic [CNT_BITS-1:0] disks_reg      = 4'd8;

  placement_t pending[$];
  int         mismatches = 0;
  int         burst_left = 0;
  int         n_writes   = 0;
  int         n_allocs   = 0;
  int         n_placed   = 0;

  rx_mode_t rx_mode = RX_OPEN;
  int       rx_run  = 0;

  plan_row_t plan [PLAN_ROWS] = '{
    // after reset every entry is zero: size zero fits at once, anything else fails
    '{CMD_ALLOCATE, 48'd0,    3'd0, 3'd0, 48'd0,    1'b1, 1'b1, 3'd0, 3'd0},
    '{CMD_ALLOCATE, 48'd1,    3'd0, 3'd0, 48'd0,    1'b1, 1'b0, 3'd0, 3'd0},
    '{CMD_ALLOCATE, SIZE_MAX, 3'd0, 3'd0, 48'd0,    1'b1, 1'b0, 3'd0, 3'd0},
    '{CMD_WRITE,    48'd0,    3'd7, 3'd7, SIZE_MAX, 1'b1, 1'b0, 3'd0, 3'd0},
    '{CMD_ALLOCATE, SIZE_MAX, 3'd0, 3'd0, 48'd0,    1'b0, 1'b0, 3'd0, 3'd0},
    '{CMD_ALLOCATE, SIZE_MAX, 3'd0, 3'd0, 48'd0,    1'b0, 1'b0, 3'd0, 3'd0},
    '{CMD_WRITE,    48'd0,    3'd0, 3'd0, 48'd0,    1'b1, 1'b0, 3'd0, 3'd0},
    '{CMD_WRITE,    48'd0,    3'd2, 3'd3, 48'h5555_5555_5555, 1'b1, 1'b0, 3'd0, 3'd0},
    '{CMD_WRITE,    48'd0,    3'd5, 3'd1, 48'hAAAA_AAAA_AAAA, 1'b1, 1'b0, 3'd0, 3'd0},
    '{CMD_ALLOCATE, 48'h5555_5555_5555, 3'd0, 3'd0, 48'd0, 1'b0, 1'b0, 3'd0, 3'd0},
    '{CMD_ALLOCATE, 48'h5555_5555_5555, 3'd0, 3'd0, 48'd0, 1'b0, 1'b0, 3'd0, 3'd0},
    '{CMD_ALLOCATE, 48'h5555_5555_5556, 3'd0, 3'd0, 48'd0, 1'b0, 1'b0, 3'd0, 3'd0},
    '{CMD_WRITE,    48'd0,    3'd7, 3'd7, 48'd0,    1'b1, 1'b0, 3'd0, 3'd0},
    '{CMD_ALLOCATE, 48'd1,    3'd0, 3'd0, 48'd0,    1'b0, 1'b0, 3'd0, 3'd0},
    '{CMD_WRITE,    48'd0,    3'd4, 3'd6, 48'd100,  1'b1, 1'b0, 3'd0, 3'd0},
    '{CMD_ALLOCATE, 48'd100,  3'd0, 3'd0, 48'd0,    1'b0, 1'b0, 3'd0, 3'd0},
    '{CMD_ALLOCATE, 48'd101,  3'd0, 3'd0, 48'd0,    1'b0, 1'b0, 3'd0, 3'd0},
    '{CMD_ALLOCATE, 48'd0,    3'd0, 3'd0, 48'd0,    1'b0, 1'b0, 3'd0, 3'd0},
    '{CMD_WRITE,    SIZE_MAX, 3'd0, 3'd7, SIZE_MAX, 1'b1, 1'b0, 3'd0, 3'd0},
    '{CMD_WRITE,    SIZE_MAX, 3'd7, 3'd0, SIZE_MAX, 1'b1, 1'b0, 3'd0, 3'd0},
    '{CMD_ALLOCATE, SIZE_MAX, 3'd7, 3'd7, SIZE_MAX, 1'b0, 1'b0, 3'd0, 3'd0},
    '{CMD_ALLOCATE, SIZE_MAX, 3'd7, 3'd7, SIZE_MAX, 1'b0, 1'b0, 3'd0, 3'd0},
    '{CMD_ALLOCATE, SIZE_MAX, 3'd7, 3'd7, SIZE_MAX, 1'b0, 1'b0, 3'd0, 3'd0}
  };

  logic [CNT_BITS-1:0] phase_servers [NUM_PHASES] = '{
    4'd0, 4'd15, 4'd1, 4'd8, 4'd3, 4'd9, 4'd2, 4'd8, 4'd5, 4'd1, 4'd7, 4'd4
  };
  logic [CNT_BITS-1:0] phase_disks [NUM_PHASES] = '{
    4'd0, 4'd15, 4'd8, 4'd1, 4'd5, 4'd2, 4'd7, 4'd8, 4'd1, 4'd1, 4'd3, 4'd6
  };

  round_robin_disk_allocator i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .request_size  (request_size),
    .target_server (target_server),
    .target_disk   (target_disk),
    .space_value   (space_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .found         (found),
    .chosen_server (chosen_server),
    .chosen_disk   (chosen_disk),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int in_use(input logic [CNT_BITS-1:0] cnt, input int top);
    if (cnt == '0) return 1;
    if (int'(cnt) > top) return top;
    return int'(cnt);
  endfunction

  // applies one item to the local state and returns the placement it yields
  function automatic placement_t place(input logic cmd, input logic [SIZE_BITS-1:0] req,
                                       input logic [IDX_BITS-1:0] ts,
                                       input logic [IDX_BITS-1:0] td,
                                       input logic [SIZE_BITS-1:0] val);
    placement_t r;
    int         ns;
    int         nd;
    int         first;
    int         srv;
    int         off;
    int         dsk;
    int         nsrv;
    int         noff;
    bit         searching;
    r = '0;
    if (cmd == CMD_WRITE) begin
      space_copy[int'(ts) * MAX_DISKS + int'(td)] = space_t'(val);
      return r;
    end
    ns        = in_use(servers_reg, MAX_SERVERS);
    nd        = in_use(disks_reg, MAX_DISKS);
    first     = (saved_server < ns) ? saved_server : 0;
    srv       = first;
    off       = 0;
    searching = 1'b1;
    while (searching) begin
      dsk = (saved_rotation + off) % nd;
      if (space_copy[srv * MAX_DISKS + dsk] >= req) begin
        nsrv = srv + 1;
        noff = off;
        if (nsrv >= ns) begin
          nsrv = 0;
          noff++;
        end
        r.found        = 1'b1;
        r.srv          = IDX_BITS'(srv);
        r.dsk          = IDX_BITS'(dsk);
        saved_server   = nsrv;
        saved_rotation = (saved_rotation + noff) % nd;
        searching      = 1'b0;
      end else begin
        srv++;
        if (srv >= ns) begin
          srv = 0;
          off++;
        end
        // a failed search leaves the saved position alone
        if (off > nd + 1 && srv == first) begin
          searching = 1'b0;
        end
      end
    end
    return r;
  endfunction

  task automatic send_item(input logic cmd, input logic [SIZE_BITS-1:0] req,
                           input logic [IDX_BITS-1:0] ts, input logic [IDX_BITS-1:0] td,
                           input logic [SIZE_BITS-1:0] val, input logic given,
                           input placement_t want);
    placement_t p;
    if (burst_left == 0) begin
      if (in_valid) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid      <= 1'b1;
    command       <= cmd;
    request_size  <= req;
    target_server <= ts;
    target_disk   <= td;
    space_value   <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = place(cmd, req, ts, td, val);
    if (cmd == CMD_WRITE) begin
      n_writes++;
    end else begin
      n_allocs++;
      if (p.found) n_placed++;
    end
    pending.insert(pending.size(), given ? want : p);
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CNT_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_SERVER_COUNT) servers_reg = val;
    else if (idx == CFG_DISK_COUNT) disks_reg = val;
  endtask

  task automatic send_random();
    logic                 cmd;
    logic [SIZE_BITS-1:0] req;
    logic [SIZE_BITS-1:0] val;
    logic [IDX_BITS-1:0]  ts;
    logic [IDX_BITS-1:0]  td;
    int                   ns;
    int                   nd;
    ns  = in_use(servers_reg, MAX_SERVERS);
    nd  = in_use(disks_reg, MAX_DISKS);
    cmd = ($urandom_range(0, 99) < 45) ? CMD_WRITE : CMD_ALLOCATE;
    // mostly aim at entries the search can reach
    if ($urandom_range(0, 4) == 0) begin
      ts = IDX_BITS'($urandom_range(0, 7));
      td = IDX_BITS'($urandom_range(0, 7));
    end else begin
      ts = IDX_BITS'($urandom_range(0, ns - 1));
      td = IDX_BITS'($urandom_range(0, nd - 1));
    end
    case ($urandom_range(0, 5))
      0:       val = '0;
      1:       val = SIZE_MAX;
      2, 3:    val = SIZE_BITS'({$urandom, $urandom});
      default: val = SIZE_BITS'($urandom_range(0, 4000));
    endcase
    case ($urandom_range(0, 5))
      0:       req = '0;
      1:       req = SIZE_MAX;
      2:       req = SIZE_BITS'({$urandom, $urandom});
      3:       req = SIZE_BITS'($urandom_range(0, 4000));
      // right at or just past a stored value
      default: req = space_copy[int'(ts) * MAX_DISKS + int'(td)] + $urandom_range(0, 1);
    endcase
    send_item(cmd, req, ts, td, val, 1'b0, '0);
  endtask

  always @(posedge clk) begin
    if (rx_run == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_run  = $urandom_range(40, 300);
    end
    rx_run--;
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_HALF:   out_ready <= rx_run[0];
      RX_SPOTTY: out_ready <= ($urandom_range(0, 9) > 2);
      default:   out_ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  always @(posedge clk) begin
    placement_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending.size() == 0) begin
        $error("unexpected result: found=%0d server=%0d disk=%0d",
               found, chosen_server, chosen_disk);
        mismatches++;
      end else begin
        want = pending.pop_front();
        if (found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, found);
          mismatches++;
        end
        if (chosen_server !== want.srv) begin
          $error("chosen_server: expected %0d, got %0d", want.srv, chosen_server);
          mismatches++;
        end
        if (chosen_disk !== want.dsk) begin
          $error("chosen_disk: expected %0d, got %0d", want.dsk, chosen_disk);
          mismatches++;
        end
      end
    end
  end

  initial begin
    placement_t want;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (plan[i]) begin
      want = '{plan[i].want_found, plan[i].want_srv, plan[i].want_dsk};
      send_item(plan[i].cmd, plan[i].req, plan[i].srv, plan[i].dsk, plan[i].space,
                plan[i].given, want);
    end
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      if ($urandom_range(0, 1)) begin
        write_reg(CFG_SERVER_COUNT, phase_servers[ph]);
        write_reg(CFG_DISK_COUNT, phase_disks[ph]);
      end else begin
        write_reg(CFG_DISK_COUNT, phase_disks[ph]);
        write_reg(CFG_SERVER_COUNT, phase_servers[ph]);
      end
      if (ph % 3 == 0) begin
        write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                  CNT_BITS'($urandom_range(0, 15)));
      end
      cfg_valid <= 1'b0;
      repeat (RANDOM_ITEMS / NUM_PHASES) begin
        if ($urandom_range(0, 39) == 0) drain();
        send_random();
      end
    end
    drain();
    repeat (100) @(posedge clk);
    $display("ran %0d writes and %0d allocates, %0d allocates placed a request",
             n_writes, n_allocs, n_placed);
    $display("register settings visited: %0d, including zero and oversized counts",
             NUM_PHASES + 1);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule

// File: round_robin_disk_allocator.f
+incdir+rtl/core
rtl/core/rrda_pkg.sv
rtl/core/rrda_table.sv
rtl/core/rrda_ctrl.sv
rtl/core/round_robin_disk_allocator.sv
rtl/core/rrda_checker.sv
tb/tb_top.sv
